@@ rtl/core/vsfe_pkg.sv @@
// Shared constants, types and helpers of the voxel shape fill engine.
package vsfe_pkg;

  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_Z = 32;
  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int GX_W   = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int GY_W   = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int GZ_W   = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam int PREP_CYCLES = 3;

  typedef enum logic [3:0] {
    OP_PUT_VOXEL = 4'd0,
    OP_CUT_VOXEL = 4'd1,
    OP_PUT_BOX   = 4'd2,
    OP_CUT_BOX   = 4'd3,
    OP_PUT_SPH   = 4'd4,
    OP_CUT_SPH   = 4'd5,
    OP_PUT_ELL   = 4'd6,
    OP_CUT_ELL   = 4'd7,
    OP_READ      = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_ALPHA = 2'd3
  } reg_e;

  typedef struct packed {
    logic latch;
    logic point_wr;
    logic sweep_en;
    logic clear_en;
    logic load_res;
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       clear_last;
    logic       sweep_last;
    logic       pipe_empty;
  } status_t;

  function automatic logic [IDX_W-1:0] cell_idx(input logic [7:0] x, input logic [7:0] y,
                                                input logic [7:0] z);
    logic [31:0] t;
    t = (32'(x) * 32'(GRID_Y) + 32'(y)) * 32'(GRID_Z) + 32'(z);
    return t[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/core/vsfe_ctrl.sv @@
// Sequencer of the voxel shape fill engine: clearing pass, dispatch, sweep and result.
module vsfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  vsfe_pkg::status_t status_i,
  output vsfe_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_PREP, ST_SWEEP, ST_DRAIN, ST_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] prep_q, prep_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    prep_d      = prep_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        prep_d = '0;
        unique case (status_i.op)
          vsfe_pkg::OP_PUT_VOXEL, vsfe_pkg::OP_CUT_VOXEL: begin
            cmd_o.point_wr = 1'b1;
            state_d        = ST_FINISH;
          end
          vsfe_pkg::OP_PUT_BOX, vsfe_pkg::OP_CUT_BOX, vsfe_pkg::OP_PUT_SPH,
          vsfe_pkg::OP_CUT_SPH, vsfe_pkg::OP_PUT_ELL, vsfe_pkg::OP_CUT_ELL: begin
            state_d = ST_PREP;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_PREP: begin
        prep_d = prep_q + 2'd1;
        if (prep_q == 2'(vsfe_pkg::PREP_CYCLES - 1)) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
        if (status_i.sweep_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_res = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      prep_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prep_q      <= prep_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/vsfe_dp.sv @@
// Datapath: request registers, sweep counters, shape test pipeline and voxel memories.
module vsfe_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  vsfe_pkg::cmd_t         cmd_i,
  output vsfe_pkg::status_t      status_o,
  input  logic [3:0]             req_type_i,
  input  logic signed [7:0]      x_first_i,
  input  logic signed [7:0]      x_last_i,
  input  logic signed [7:0]      y_first_i,
  input  logic signed [7:0]      y_last_i,
  input  logic signed [7:0]      z_first_i,
  input  logic signed [7:0]      z_last_i,
  input  logic [6:0]             radius_x_i,
  input  logic [6:0]             radius_y_i,
  input  logic [6:0]             radius_z_i,
  input  logic [31:0]            paint_i,
  output logic                   voxel_on_o,
  output logic [31:0]            voxel_rgba_o
);

  localparam int IW = vsfe_pkg::IDX_W;

  // request
  logic [3:0]        op_q;
  logic signed [7:0] x0_q, x1_q, y0_q, y1_q, z0_q, z1_q;
  logic [6:0]        rx_q, ry_q, rz_q;

  // precompute
  logic [13:0] rx2_q, ry2_q, rz2_q;
  logic [27:0] ryrz_q, rxrz_q, rxry_q;
  logic [41:0] rhs_q;

  // counters
  logic [vsfe_pkg::GX_W-1:0] ci_q;
  logic [vsfe_pkg::GY_W-1:0] cj_q;
  logic [vsfe_pkg::GZ_W-1:0] ck_q;
  logic [IW-1:0]             clr_q;

  // pipeline
  logic              v1_q, v2_q;
  logic [IW-1:0]     idx1_q, idx2_q;
  logic              box1_q, box2_q, sph2_q;
  logic [15:0]       dx2_q, dy2_q, dz2_q;
  logic [43:0]       px_q, py_q, pz_q;

  // memories
  logic          on_mem [vsfe_pkg::CELLS];
  logic [31:0]   col_mem [vsfe_pkg::CELLS];
  logic          rd_on_q;
  logic [31:0]   rd_col_q;

  logic          set_op, is_box_put, is_box, is_sph, is_ell;
  logic          in_grid;
  logic [IW-1:0] pt_idx, s0_idx;
  logic signed [9:0] dx, dy, dz;
  logic [7:0]    ax, ay, az;
  logic          box0, hit2, ell2;
  logic          we_on, we_col, wd_on;
  logic [IW-1:0] waddr;
  logic [31:0]   wd_col;
  logic [45:0]   ell_sum;

  assign set_op     = ~op_q[0];
  assign is_box_put = (op_q == vsfe_pkg::OP_PUT_BOX);
  assign is_box     = is_box_put || (op_q == vsfe_pkg::OP_CUT_BOX);
  assign is_sph     = (op_q == vsfe_pkg::OP_PUT_SPH) || (op_q == vsfe_pkg::OP_CUT_SPH);
  assign is_ell     = (op_q == vsfe_pkg::OP_PUT_ELL) || (op_q == vsfe_pkg::OP_CUT_ELL);

  assign in_grid = !x0_q[7] && !y0_q[7] && !z0_q[7] &&
                   (8'(x0_q) < 8'(vsfe_pkg::GRID_X)) &&
                   (8'(y0_q) < 8'(vsfe_pkg::GRID_Y)) &&
                   (8'(z0_q) < 8'(vsfe_pkg::GRID_Z));
  assign pt_idx  = vsfe_pkg::cell_idx(8'(x0_q), 8'(y0_q), 8'(z0_q));
  assign s0_idx  = vsfe_pkg::cell_idx(8'(ci_q), 8'(cj_q), 8'(ck_q));

  always_comb begin
    dx = signed'(10'(ci_q)) - 10'(x0_q);
    dy = signed'(10'(cj_q)) - 10'(y0_q);
    dz = signed'(10'(ck_q)) - 10'(z0_q);
    ax = dx[9] ? 8'(-dx) : 8'(dx);
    ay = dy[9] ? 8'(-dy) : 8'(dy);
    az = dz[9] ? 8'(-dz) : 8'(dz);
    box0 = (signed'(9'(ci_q)) >= 9'(x0_q)) && (signed'(9'(cj_q)) >= 9'(y0_q)) &&
           (signed'(9'(ck_q)) >= 9'(z0_q));
    if (is_box_put) begin
      box0 = box0 && (signed'(9'(ci_q)) < 9'(x1_q)) && (signed'(9'(cj_q)) < 9'(y1_q)) &&
             (signed'(9'(ck_q)) < 9'(z1_q));
    end else begin
      box0 = box0 && (signed'(9'(ci_q)) <= 9'(x1_q)) && (signed'(9'(cj_q)) <= 9'(y1_q)) &&
             (signed'(9'(ck_q)) <= 9'(z1_q));
    end
  end

  assign ell_sum = 46'(px_q) + 46'(py_q) + 46'(pz_q);
  assign ell2    = (rhs_q != '0) && (ell_sum < 46'(rhs_q));
  assign hit2    = is_box ? box2_q : (is_sph ? sph2_q : (is_ell && ell2));

  always_comb begin
    we_on  = 1'b0;
    we_col = 1'b0;
    waddr  = idx2_q;
    wd_on  = set_op;
    wd_col = paint_i;
    if (cmd_i.clear_en) begin
      we_on  = 1'b1;
      we_col = 1'b1;
      waddr  = clr_q;
      wd_on  = 1'b0;
      wd_col = '0;
    end else if (cmd_i.point_wr) begin
      we_on  = in_grid;
      we_col = in_grid && set_op;
      waddr  = pt_idx;
    end else if (v2_q) begin
      we_on  = hit2;
      we_col = hit2 && set_op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_on) on_mem[waddr] <= wd_on;
    if (we_col) col_mem[waddr] <= wd_col;
    rd_on_q  <= on_mem[pt_idx];
    rd_col_q <= col_mem[pt_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= req_type_i;
      x0_q <= x_first_i;
      x1_q <= x_last_i;
      y0_q <= y_first_i;
      y1_q <= y_last_i;
      z0_q <= z_first_i;
      z1_q <= z_last_i;
      rx_q <= radius_x_i;
      ry_q <= radius_y_i;
      rz_q <= radius_z_i;
    end
    rx2_q  <= 14'(rx_q) * 14'(rx_q);
    ry2_q  <= 14'(ry_q) * 14'(ry_q);
    rz2_q  <= 14'(rz_q) * 14'(rz_q);
    ryrz_q <= 28'(ry2_q) * 28'(rz2_q);
    rxrz_q <= 28'(rx2_q) * 28'(rz2_q);
    rxry_q <= 28'(rx2_q) * 28'(ry2_q);
    rhs_q  <= 42'(rx2_q) * 42'(ryrz_q);
    idx1_q <= s0_idx;
    box1_q <= box0;
    dx2_q  <= 16'(ax) * 16'(ax);
    dy2_q  <= 16'(ay) * 16'(ay);
    dz2_q  <= 16'(az) * 16'(az);
    idx2_q <= idx1_q;
    box2_q <= box1_q;
    sph2_q <= (18'(dx2_q) + 18'(dy2_q) + 18'(dz2_q)) < 18'(rx2_q);
    px_q   <= 44'(dx2_q) * 44'(ryrz_q);
    py_q   <= 44'(dy2_q) * 44'(rxrz_q);
    pz_q   <= 44'(dz2_q) * 44'(rxry_q);
    if (cmd_i.load_res) begin
      voxel_on_o   <= (op_q == vsfe_pkg::OP_READ) && in_grid && rd_on_q;
      voxel_rgba_o <= ((op_q == vsfe_pkg::OP_READ) && in_grid) ? rd_col_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q  <= '0;
      cj_q  <= '0;
      ck_q  <= '0;
      clr_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      v1_q <= cmd_i.sweep_en;
      v2_q <= v1_q;
      if (cmd_i.clear_en) clr_q <= clr_q + IW'(1);
      if (cmd_i.latch) begin
        ci_q <= '0;
        cj_q <= '0;
        ck_q <= '0;
      end else if (cmd_i.sweep_en) begin
        if (ck_q == vsfe_pkg::GZ_W'(vsfe_pkg::GRID_Z - 1)) begin
          ck_q <= '0;
          if (cj_q == vsfe_pkg::GY_W'(vsfe_pkg::GRID_Y - 1)) begin
            cj_q <= '0;
            ci_q <= ci_q + vsfe_pkg::GX_W'(1);
          end else begin
            cj_q <= cj_q + vsfe_pkg::GY_W'(1);
          end
        end else begin
          ck_q <= ck_q + vsfe_pkg::GZ_W'(1);
        end
      end
    end
  end

  assign status_o.op         = op_q;
  assign status_o.clear_last = (clr_q == IW'(vsfe_pkg::CELLS - 1));
  assign status_o.sweep_last = (ci_q == vsfe_pkg::GX_W'(vsfe_pkg::GRID_X - 1)) &&
                               (cj_q == vsfe_pkg::GY_W'(vsfe_pkg::GRID_Y - 1)) &&
                               (ck_q == vsfe_pkg::GZ_W'(vsfe_pkg::GRID_Z - 1));
  assign status_o.pipe_empty = !v1_q && !v2_q;

endmodule

@@ rtl/core/voxel_shape_fill_engine_top.sv @@
// Top level of the voxel shape fill engine: paint registers, sequencer and datapath.
//
// Request channel (in_valid_i / in_stall_o) takes one command word; result channel
// (out_valid_o / out_stall_i) returns exactly one result word per command. Reads
// inside the grid give the stored voxel; every other command returns all zero fields.
// Box, sphere and ellipsoid commands sweep all GRID_X*GRID_Y*GRID_Z voxels, testing
// one voxel per cycle in a three-stage pipeline against the single write port of the
// voxel memories. One command is in work at a time. in_stall_o is high until the
// result is registered, so a new word can be taken while the last result is stalled.
// After reset a clearing pass over all GRID_X*GRID_Y*GRID_Z cells zeroes the store;
// in_stall_o stays high through it. Paint registers sit on the APB port at byte
// addresses 0, 4, 8, 12 (red, green, blue, alpha); the user must see that they are
// written only while idle, as the block itself does not enforce it.
// A stalled result holds; the block finishes its work and waits to hand it over.
module voxel_shape_fill_engine_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        req_type_i,
  input  logic signed [7:0] x_first_i,
  input  logic signed [7:0] x_last_i,
  input  logic signed [7:0] y_first_i,
  input  logic signed [7:0] y_last_i,
  input  logic signed [7:0] z_first_i,
  input  logic signed [7:0] z_last_i,
  input  logic [6:0]        radius_x_i,
  input  logic [6:0]        radius_y_i,
  input  logic [6:0]        radius_z_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              voxel_on_o,
  output logic [7:0]        voxel_red_o,
  output logic [7:0]        voxel_green_o,
  output logic [7:0]        voxel_blue_o,
  output logic [7:0]        voxel_alpha_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic [31:0] rgba;
  vsfe_pkg::cmd_t    cmd;
  vsfe_pkg::status_t status;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      alpha_q <= '0;
    end else if (cfg_wr) begin
      unique case (vsfe_pkg::reg_e'(paddr[3:2]))
        vsfe_pkg::REG_RED:   red_q   <= pwdata[7:0];
        vsfe_pkg::REG_GREEN: green_q <= pwdata[7:0];
        vsfe_pkg::REG_BLUE:  blue_q  <= pwdata[7:0];
        vsfe_pkg::REG_ALPHA: alpha_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (vsfe_pkg::reg_e'(paddr[3:2]))
      vsfe_pkg::REG_RED:   prdata = 32'(red_q);
      vsfe_pkg::REG_GREEN: prdata = 32'(green_q);
      vsfe_pkg::REG_BLUE:  prdata = 32'(blue_q);
      vsfe_pkg::REG_ALPHA: prdata = 32'(alpha_q);
      default:             prdata = '0;
    endcase
  end

  assign rgba = {alpha_q, blue_q, green_q, red_q};

  logic [31:0] res_rgba;

  vsfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vsfe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (req_type_i),
    .x_first_i    (x_first_i),
    .x_last_i     (x_last_i),
    .y_first_i    (y_first_i),
    .y_last_i     (y_last_i),
    .z_first_i    (z_first_i),
    .z_last_i     (z_last_i),
    .radius_x_i   (radius_x_i),
    .radius_y_i   (radius_y_i),
    .radius_z_i   (radius_z_i),
    .paint_i      (rgba),
    .voxel_on_o   (voxel_on_o),
    .voxel_rgba_o (res_rgba)
  );

  assign voxel_red_o   = res_rgba[7:0];
  assign voxel_green_o = res_rgba[15:8];
  assign voxel_blue_o  = res_rgba[23:16];
  assign voxel_alpha_o = res_rgba[31:24];

  // busy straight after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while not busy");

  // a new result only comes from a command in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a command");

endmodule

@@ bench/tb_voxel_shape_fill_engine_top.sv @@
// Self-checking bench for the voxel shape fill engine: commands, paint registers and reads.
module tb_voxel_shape_fill_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic [3:0]        req;
    logic signed [7:0] x0, x1, y0, y1, z0, z1;
    logic [6:0]        rx, ry, rz;
  } voxel_cmd_t;

  typedef struct packed {
    logic       on;
    logic [7:0] r, g, b, a;
  } voxel_res_t;

  class voxel_scoreboard;
    bit         cell_on [vsfe_pkg::CELLS];
    logic [7:0] cell_rgba [vsfe_pkg::CELLS][4];
    logic [7:0] paint [4];
    voxel_res_t awaited [$];
    int         errors;
    int         words_in;
    int         words_out;
    int         sweeps;

    function void clear_all();
      foreach (cell_on[i]) begin
        cell_on[i] = 0;
        for (int c = 0; c < 4; c++) cell_rgba[i][c] = '0;
      end
      for (int c = 0; c < 4; c++) paint[c] = '0;
    endfunction

    function void set_paint(int idx, logic [7:0] v);
      paint[idx] = v;
    endfunction

    function void mark(int idx, bit set);
      cell_on[idx] = set;
      if (set) for (int c = 0; c < 4; c++) cell_rgba[idx][c] = paint[c];
    endfunction

    function longint sqd(int d);
      longint m;
      m = (d < 0) ? -d : d;
      return m * m;
    endfunction

    function void note_command(voxel_cmd_t w);
      voxel_res_t res;
      int x0, x1, y0, y1, z0, z1;
      longint rx2, ry2, rz2;
      bit set, hit, inside_grid;
      x0 = w.x0; x1 = w.x1; y0 = w.y0; y1 = w.y1; z0 = w.z0; z1 = w.z1;
      rx2 = longint'(w.rx) * w.rx;
      ry2 = longint'(w.ry) * w.ry;
      rz2 = longint'(w.rz) * w.rz;
      set = !w.req[0];
      res = '0;
      inside_grid = x0 >= 0 && x0 < vsfe_pkg::GRID_X && y0 >= 0 && y0 < vsfe_pkg::GRID_Y &&
                    z0 >= 0 && z0 < vsfe_pkg::GRID_Z;
      words_in++;
      if (w.req <= vsfe_pkg::OP_CUT_VOXEL) begin
        if (inside_grid) mark((x0 * vsfe_pkg::GRID_Y + y0) * vsfe_pkg::GRID_Z + z0, set);
      end else if (w.req <= vsfe_pkg::OP_CUT_ELL) begin
        sweeps++;
        for (int i = 0; i < vsfe_pkg::GRID_X; i++)
          for (int j = 0; j < vsfe_pkg::GRID_Y; j++)
            for (int k = 0; k < vsfe_pkg::GRID_Z; k++) begin
              case (w.req)
                vsfe_pkg::OP_PUT_BOX: hit = i >= x0 && i < x1 && j >= y0 && j < y1 &&
                                            k >= z0 && k < z1;
                vsfe_pkg::OP_CUT_BOX: hit = i >= x0 && i <= x1 && j >= y0 && j <= y1 &&
                                            k >= z0 && k <= z1;
                vsfe_pkg::OP_PUT_SPH, vsfe_pkg::OP_CUT_SPH:
                  hit = sqd(i - x0) + sqd(j - y0) + sqd(k - z0) < rx2;
                default: hit = w.rx != 0 && w.ry != 0 && w.rz != 0 &&
                               sqd(i - x0) * ry2 * rz2 + sqd(j - y0) * rx2 * rz2 +
                               sqd(k - z0) * rx2 * ry2 < rx2 * ry2 * rz2;
              endcase
              if (hit) mark((i * vsfe_pkg::GRID_Y + j) * vsfe_pkg::GRID_Z + k, set);
            end
      end else if (w.req == vsfe_pkg::OP_READ && inside_grid) begin
        int idx;
        idx = (x0 * vsfe_pkg::GRID_Y + y0) * vsfe_pkg::GRID_Z + z0;
        res.on = cell_on[idx];
        res.r = cell_rgba[idx][0];
        res.g = cell_rgba[idx][1];
        res.b = cell_rgba[idx][2];
        res.a = cell_rgba[idx][3];
      end
      awaited.push_back(res);
    endfunction

    function void check_result(voxel_res_t got);
      voxel_res_t want;
      words_out++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.on !== want.on) begin
        $display("%0t: voxel_on expected %0d got %0d", $time, want.on, got.on); errors++;
      end
      if (got.r !== want.r) begin
        $display("%0t: voxel_red expected %0d got %0d", $time, want.r, got.r); errors++;
      end
      if (got.g !== want.g) begin
        $display("%0t: voxel_green expected %0d got %0d", $time, want.g, got.g); errors++;
      end
      if (got.b !== want.b) begin
        $display("%0t: voxel_blue expected %0d got %0d", $time, want.b, got.b); errors++;
      end
      if (got.a !== want.a) begin
        $display("%0t: voxel_alpha expected %0d got %0d", $time, want.a, got.a); errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [3:0]        req_type_i;
  logic signed [7:0] x_first_i, x_last_i, y_first_i, y_last_i, z_first_i, z_last_i;
  logic [6:0]        radius_x_i, radius_y_i, radius_z_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              voxel_on_o;
  logic [7:0]        voxel_red_o, voxel_green_o, voxel_blue_o, voxel_alpha_o;
  logic              psel, penable, pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  voxel_shape_fill_engine_top dut (.*);

  voxel_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int quiet_cycles;

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result({voxel_on_o, voxel_red_o, voxel_green_o, voxel_blue_o, voxel_alpha_o});
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("tb_voxel_shape_fill_engine_top: errors");
        $finish;
      end
    end
  end

  task automatic send_word(voxel_cmd_t w);
    in_valid_i <= 1'b1;
    req_type_i <= w.req;
    x_first_i <= w.x0; x_last_i <= w.x1;
    y_first_i <= w.y0; y_last_i <= w.y1;
    z_first_i <= w.z0; z_last_i <= w.z1;
    radius_x_i <= w.rx; radius_y_i <= w.ry; radius_z_i <= w.rz;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic apb_write(vsfe_pkg::reg_e r, logic [7:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0;
    sb.set_paint(r, v);
  endtask

  task automatic set_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    apb_write(vsfe_pkg::REG_RED, r);
    apb_write(vsfe_pkg::REG_GREEN, g);
    apb_write(vsfe_pkg::REG_BLUE, b);
    apb_write(vsfe_pkg::REG_ALPHA, a);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic voxel_cmd_t mk(vsfe_pkg::op_e op, int x0, int x1, int y0, int y1,
                                    int z0, int z1, int rx, int ry, int rz);
    voxel_cmd_t w;
    w.req = op;
    w.x0 = 8'(x0); w.x1 = 8'(x1); w.y0 = 8'(y0); w.y1 = 8'(y1);
    w.z0 = 8'(z0); w.z1 = 8'(z1);
    w.rx = 7'(rx); w.ry = 7'(ry); w.rz = 7'(rz);
    return w;
  endfunction

  function automatic logic [7:0] rand_coord();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return 8'(int'($urandom_range(0, 40)) - 4);
  endfunction

  function automatic voxel_cmd_t rand_word(bit shapes);
    voxel_cmd_t w;
    logic [95:0] raw;
    int pick;
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(voxel_cmd_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 35) w.req = 4'($urandom_range(0, 1));
    else if (pick < 75) w.req = vsfe_pkg::OP_READ;
    else if (pick < 80) w.req = 4'($urandom_range(9, 15));
    else if (shapes) w.req = 4'($urandom_range(2, 7));
    else w.req = vsfe_pkg::OP_READ;
    if ($urandom_range(3) != 0) begin
      w.x0 = rand_coord(); w.y0 = rand_coord(); w.z0 = rand_coord();
      w.x1 = rand_coord(); w.y1 = rand_coord(); w.z1 = rand_coord();
    end
    if ($urandom_range(2) != 0) begin
      w.rx = 7'($urandom_range(0, 12));
      w.ry = 7'($urandom_range(0, 12));
      w.rz = 7'($urandom_range(0, 12));
    end
    return w;
  endfunction

  initial begin
    sb = new();
    sb.clear_all();
    rst_ni = 1'b0;
    in_valid_i = 1'b0; out_stall_i = 1'b0;
    req_type_i = '0;
    x_first_i = '0; x_last_i = '0; y_first_i = '0; y_last_i = '0; z_first_i = '0; z_last_i = '0;
    radius_x_i = '0; radius_y_i = '0; radius_z_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; stall_pct = 0; hold_req = 0; quiet_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_word(mk(vsfe_pkg::OP_READ, 5, 0, 5, 0, 5, 0, 0, 0, 0));
    drain();
    set_colour(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(mk(vsfe_pkg::OP_PUT_VOXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_PUT_VOXEL, 31, 0, 31, 0, 31, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_PUT_VOXEL, -128, 0, 127, 0, 32, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_READ, 31, 0, 31, 0, 31, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_READ, -1, 0, 127, 0, -128, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_CUT_VOXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    set_colour(8'h12, 8'h34, 8'h56, 8'h78);
    send_word(mk(vsfe_pkg::OP_PUT_BOX, 2, 6, 2, 6, 2, 6, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_READ, 5, 0, 5, 0, 5, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_READ, 6, 0, 5, 0, 5, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_CUT_BOX, 28, 127, -128, 31, 28, 31, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_READ, 31, 0, 31, 0, 31, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_PUT_SPH, 16, 0, 16, 0, 16, 0, 4, 0, 0));
    send_word(mk(vsfe_pkg::OP_READ, 19, 0, 16, 0, 16, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_READ, 20, 0, 16, 0, 16, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_CUT_SPH, 16, 0, 16, 0, 16, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_PUT_ELL, 8, 0, 24, 0, 10, 0, 6, 3, 2));
    send_word(mk(vsfe_pkg::OP_CUT_ELL, 8, 0, 24, 0, 10, 0, 127, 0, 127));
    send_word(mk(vsfe_pkg::OP_READ, 13, 0, 24, 0, 10, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::OP_PUT_VOXEL, 1, 0, 1, 0, 1, 0, 0, 0, 0));
    send_word(mk(vsfe_pkg::op_e'(4'd15), 1, 0, 1, 0, 1, 0, 0, 0, 0));
    drain();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      if (ph == 3) set_colour(8'h00, 8'h00, 8'h00, 8'h00);
      else set_colour(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 19; n++) send_word(rand_word(!(ph == 2 && n < 12)));
      drain();
    end
    stall_pct = 0;
    repeat (20) @(posedge clk_i);

    $display("run covered %0d command words, %0d results, %0d full-grid sweeps",
             sb.words_in, sb.words_out, sb.sweeps);
    $display("paint registers at extremes and random values, four idling regimes");
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) $display("tb_voxel_shape_fill_engine_top: clean");
    else $display("tb_voxel_shape_fill_engine_top: errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/vsfe_pkg.sv
rtl/core/vsfe_ctrl.sv
rtl/core/vsfe_dp.sv
rtl/core/voxel_shape_fill_engine_top.sv
bench/tb_voxel_shape_fill_engine_top.sv
